[rtl/i2cms_pkg.sv]
// Package with the item types, opcodes and status codes of the I2C transfer sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

  // Default width of the bytes-left counter.
  localparam int COUNT_BITS_DEFAULT = 16;

  // Read bit in bit 0 of the address byte.
  localparam logic [7:0] READ_BIT = 8'h01;

  // Input item kinds.
  typedef enum logic [1:0] {
    OP_START_READ  = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_BUS_EVENT   = 2'd2,
    OP_ERROR_EVENT = 2'd3
  } i2cms_op_t;

  // Data actions on the result.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_DRIVE = 2'd1;
  localparam logic [1:0] ACT_RECV  = 2'd2;

  // Transfer status codes.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_ERROR   = 3'd3;
  localparam logic [2:0] ST_RESTART = 3'd4;

  // One input item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  target_address;
    logic [15:0] byte_count;
    logic        keep_bus;
    logic        flag_start_sent;
    logic        flag_address_sent;
    logic        flag_tx_empty;
    logic        flag_byte_finished;
    logic        flag_rx_full;
    logic [7:0]  data_byte;
    logic        error_fatal;
  } i2cms_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  data_action;
    logic [7:0]  data_value;
    logic        request_start;
    logic        request_stop;
    logic        ack_enable;
    logic        soft_reset;
    logic        event_irq_enabled;
    logic        buffer_irq_enabled;
    logic [2:0]  transfer_status;
    logic [15:0] bytes_left;
  } i2cms_out_t;

endpackage

[rtl/i2c_master_transfer_sequencer_core.sv]
// Top level of the I2C master transfer sequencer: state update and result register.
`timescale 1ns / 1ps
// The block sequences one I2C master transfer. Start commands, bus events and
// error events arrive as transfers on the in channel (in_valid/in_ready); each
// accepted item yields exactly one result on the out channel (out_valid/out_ready)
// carrying the byte to drive or the byte received, the bus requests and the status.
// The state update is one combinational pass from the accepted item and the
// transfer state into the result register, so a result appears in the cycle after
// its item is accepted. The throughput is one item per cycle: in_ready stays
// high while the result register is empty or its result is taken in the same
// cycle. When the receiver stalls, the result holds and in_ready drops until it
// is taken; the state only changes on an accepted item.
// Reset (rst, synchronous) clears all transfer state, the ever-started mark and
// the valid flag of the result register. The bytes-left counter is
// COUNT_BITS wide and saturates at zero on every count-down.
module i2c_master_transfer_sequencer_core
  import i2cms_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  i2cms_in_t  in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output i2cms_out_t out_item
);

  localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // Transfer state.
  logic [7:0]            address_byte, address_byte_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic                  error_seen, error_seen_next;
  logic                  restart_pending, restart_pending_next;
  logic                  hold_bus, hold_bus_next;
  logic                  ack_on, ack_on_next;
  logic                  event_irq_on, event_irq_on_next;
  logic                  buffer_irq_on, buffer_irq_on_next;
  logic                  ever_started, ever_started_next;

  // Result fields for the accepted item.
  logic [1:0]            action;
  logic [7:0]            value;
  logic                  req_start, req_stop, sw_reset;
  logic [2:0]            status;
  logic [EXT_BITS-1:0]   count_ext;
  logic [EXT_BITS-1:0]   left_ext;
  logic [COUNT_BITS-1:0] rem_dec;
  logic                  accept;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign count_ext = EXT_BITS'(in_item.byte_count);
  assign rem_dec   = (remaining != '0) ? remaining - CNT_ONE : remaining;

  // Next state and result for one item.
  always_comb begin
    address_byte_next    = address_byte;
    remaining_next       = remaining;
    error_seen_next      = error_seen;
    restart_pending_next = restart_pending;
    hold_bus_next        = hold_bus;
    ack_on_next          = ack_on;
    event_irq_on_next    = event_irq_on;
    buffer_irq_on_next   = buffer_irq_on;
    ever_started_next    = ever_started;
    action               = ACT_NONE;
    value                = 8'h00;
    req_start            = 1'b0;
    req_stop             = 1'b0;
    sw_reset             = 1'b0;

    case (i2cms_op_t'(in_item.opcode))
      OP_START_READ, OP_START_WRITE: begin
        address_byte_next = {in_item.target_address,
                             (in_item.opcode == OP_START_READ) ? READ_BIT[0] : 1'b0};
        remaining_next       = count_ext[COUNT_BITS-1:0];
        error_seen_next      = 1'b0;
        restart_pending_next = 1'b0;
        ack_on_next          = 1'b1;
        event_irq_on_next    = 1'b1;
        buffer_irq_on_next   = 1'b1;
        ever_started_next    = 1'b1;
        hold_bus_next        = (in_item.opcode == OP_START_WRITE) && in_item.keep_bus;
        req_start            = 1'b1;
      end
      OP_BUS_EVENT: begin
        if (event_irq_on) begin
          if (in_item.flag_start_sent) begin
            action = ACT_DRIVE;
            value  = address_byte;
          end else if (in_item.flag_address_sent) begin
            if ((address_byte & READ_BIT) == 8'h00) begin
              // Write: the first data byte goes out even with a zero count.
              action         = ACT_DRIVE;
              value          = in_item.data_byte;
              remaining_next = rem_dec;
              if (rem_dec == '0) begin
                buffer_irq_on_next = 1'b0;
              end
            end else if (remaining == CNT_ONE) begin
              // Single-byte read: no ack and stop after it.
              ack_on_next = 1'b0;
              req_stop    = 1'b1;
            end
          end else if (in_item.flag_tx_empty) begin
            if (in_item.flag_byte_finished) begin
              // Write complete: stop, or leave the bus held for a repeated start.
              if (hold_bus) begin
                hold_bus_next        = 1'b0;
                restart_pending_next = 1'b1;
              end else begin
                req_stop = 1'b1;
              end
              event_irq_on_next  = 1'b0;
              buffer_irq_on_next = 1'b0;
            end else if (remaining != '0) begin
              action         = ACT_DRIVE;
              value          = in_item.data_byte;
              remaining_next = rem_dec;
              if (rem_dec == '0) begin
                buffer_irq_on_next = 1'b0;
              end
            end
          end else if (in_item.flag_rx_full) begin
            action         = ACT_RECV;
            value          = in_item.data_byte;
            remaining_next = rem_dec;
            if (rem_dec == CNT_ONE) begin
              ack_on_next = 1'b0;
              req_stop    = 1'b1;
            end else if (rem_dec == '0) begin
              event_irq_on_next  = 1'b0;
              buffer_irq_on_next = 1'b0;
            end
          end
        end
      end
      default: begin
        // Error event: handled even with notifications off.
        if (in_item.error_fatal) begin
          sw_reset = 1'b1;
        end else begin
          req_stop = 1'b1;
        end
        error_seen_next    = 1'b1;
        event_irq_on_next  = 1'b0;
        buffer_irq_on_next = 1'b0;
      end
    endcase

    // Status after the update.
    if (error_seen_next) begin
      status = ST_ERROR;
    end else if (restart_pending_next) begin
      status = ST_RESTART;
    end else if (event_irq_on_next) begin
      status = ST_BUSY;
    end else if (ever_started_next) begin
      status = ST_DONE;
    end else begin
      status = ST_IDLE;
    end
  end

  assign left_ext = EXT_BITS'(remaining_next);

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte    <= 8'h00;
      remaining       <= '0;
      error_seen      <= 1'b0;
      restart_pending <= 1'b0;
      hold_bus        <= 1'b0;
      ack_on          <= 1'b0;
      event_irq_on    <= 1'b0;
      buffer_irq_on   <= 1'b0;
      ever_started    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        address_byte    <= address_byte_next;
        remaining       <= remaining_next;
        error_seen      <= error_seen_next;
        restart_pending <= restart_pending_next;
        hold_bus        <= hold_bus_next;
        ack_on          <= ack_on_next;
        event_irq_on    <= event_irq_on_next;
        buffer_irq_on   <= buffer_irq_on_next;
        ever_started    <= ever_started_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.data_action        <= action;
      out_item.data_value         <= value;
      out_item.request_start      <= req_start;
      out_item.request_stop       <= req_stop;
      out_item.ack_enable         <= ack_on_next;
      out_item.soft_reset         <= sw_reset;
      out_item.event_irq_enabled  <= event_irq_on_next;
      out_item.buffer_irq_enabled <= buffer_irq_on_next;
      out_item.transfer_status    <= status;
      out_item.bytes_left         <= left_ext[15:0];
    end
  end

endmodule

[rtl/i2cms_checker.sv]
// Port-level checker for the I2C transfer sequencer, bound to the top level.
`timescale 1ns / 1ps

module i2cms_checker
  import i2cms_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input i2cms_in_t  in_item,
  input logic       out_valid,
  input logic       out_ready,
  input i2cms_out_t out_item
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // A start command gives a busy result that asks for a start condition.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_item.opcode == OP_START_READ || in_item.opcode == OP_START_WRITE)
    |=> out_valid && out_item.request_start && out_item.transfer_status == ST_BUSY
        && out_item.event_irq_enabled && out_item.ack_enable)
    else $error("start command result wrong");

  // An error event ends the transfer with error status and notifications off.
  a_error: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_item.opcode == OP_ERROR_EVENT
    |=> out_valid && out_item.transfer_status == ST_ERROR
        && !out_item.event_irq_enabled && !out_item.buffer_irq_enabled
        && (out_item.soft_reset != out_item.request_stop))
    else $error("error event result wrong");

  // A result with no data action carries a zero byte.
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.data_action == ACT_NONE |-> out_item.data_value == 8'h00)
    else $error("data value set with no action");

endmodule

bind i2c_master_transfer_sequencer_core i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
